@@ hdl/bsm_pkg.sv @@
// ----------------------------------------------------------------------------
// bsm_pkg
// shared types and codes for the bank switch mapper
// ----------------------------------------------------------------------------
package bsm_pkg;

    localparam int NUM_BANK_REGS = 8;
    localparam int BANK_IDX_W    = $clog2(NUM_BANK_REGS);
    localparam int NUM_CHR_SLOTS = 8;

    localparam int ADDR_W = 16;
    localparam int DATA_W = 8;
    localparam int PHYS_W = 19;
    localparam int PRG_W  = 6;

    typedef enum logic [2:0] {
        ACT_CPU_READ  = 3'd0,
        ACT_CPU_WRITE = 3'd1,
        ACT_PPU_READ  = 3'd2,
        ACT_PPU_WRITE = 3'd3,
        ACT_SCANLINE  = 3'd4
    } action_t;

    typedef enum logic [1:0] {
        TGT_NONE    = 2'd0,
        TGT_PRG_RAM = 2'd1,
        TGT_PRG_ROM = 2'd2,
        TGT_CHR_ROM = 2'd3
    } target_t;

    // register decode
    localparam logic [ADDR_W-1:0] REG_ADDR_MASK   = 16'hE001;
    localparam logic [ADDR_W-1:0] REG_BANK_SELECT = 16'h8000;
    localparam logic [ADDR_W-1:0] REG_BANK_DATA   = 16'h8001;
    localparam logic [ADDR_W-1:0] REG_MIRROR      = 16'hA000;
    localparam logic [ADDR_W-1:0] REG_IRQ_LATCH   = 16'hC000;
    localparam logic [ADDR_W-1:0] REG_IRQ_RELOAD  = 16'hC001;
    localparam logic [ADDR_W-1:0] REG_IRQ_DISABLE = 16'hE000;
    localparam logic [ADDR_W-1:0] REG_IRQ_ENABLE  = 16'hE001;

    localparam logic [ADDR_W-1:0] PRG_RAM_BASE = 16'h6000;
    localparam logic [ADDR_W-1:0] PRG_ROM_BASE = 16'h8000;
    localparam logic [ADDR_W-1:0] CHR_TOP      = 16'h1FFF;
    localparam logic [DATA_W-1:0] CHR_PAIR_MASK = 8'hFE;
    localparam logic [PRG_W-1:0]  FIXED_OFS_LO = 6'h3E;
    localparam logic [PRG_W-1:0]  FIXED_OFS_HI = 6'h3F;

    typedef struct packed {
        logic [2:0]        action;
        logic [ADDR_W-1:0] addr;
        logic [DATA_W-1:0] data;
    } item_t;

    typedef struct packed {
        logic [NUM_CHR_SLOTS-1:0][DATA_W-1:0] chr_slot_map;
        logic [PRG_W-1:0]                     prg_first;
        logic [PRG_W-1:0]                     prg_second;
        logic                                 prg_mode;
    } map_state_t;

endpackage

@@ hdl/bsm_ctrl.sv @@
// ----------------------------------------------------------------------------
// bsm_ctrl
// mapper register file: bank select and data, slot maps, mirroring, irq counter
// ----------------------------------------------------------------------------
module bsm_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                step,
    input  bsm_pkg::item_t      item,
    output bsm_pkg::map_state_t map_state,
    output logic                irq_fire,
    output logic                mirror_next
);
    import bsm_pkg::*;

    logic [NUM_BANK_REGS-1:0][DATA_W-1:0] bank_regs_reg, bank_regs_next;
    logic [BANK_IDX_W-1:0]                reg_index_reg, reg_index_next;
    logic                                 prg_pend_reg, prg_pend_next;
    logic                                 chr_pend_reg, chr_pend_next;
    map_state_t                           map_reg, map_next;
    logic [DATA_W-1:0]                    irq_reload_reg, irq_reload_next;
    logic [DATA_W-1:0]                    irq_count_reg, irq_count_next;
    logic                                 irq_on_reg, irq_on_next;
    logic                                 mirror_reg;

    logic [DATA_W-1:0] pa;
    logic [DATA_W-1:0] pb;
    logic              is_reg_write;
    logic              is_tick;

    assign is_reg_write = (item.action == ACT_CPU_WRITE) && (item.addr >= PRG_ROM_BASE);
    assign is_tick      = (item.action == ACT_SCANLINE);

    always_comb
    begin
        bank_regs_next  = bank_regs_reg;
        reg_index_next  = reg_index_reg;
        prg_pend_next   = prg_pend_reg;
        chr_pend_next   = chr_pend_reg;
        map_next        = map_reg;
        irq_reload_next = irq_reload_reg;
        irq_count_next  = irq_count_reg;
        irq_on_next     = irq_on_reg;
        mirror_next     = mirror_reg;
        irq_fire        = 1'b0;
        pa              = '0;
        pb              = '0;

        if (is_reg_write)
        begin
            case (item.addr & REG_ADDR_MASK)
                REG_BANK_SELECT:
                begin
                    reg_index_next = item.data[BANK_IDX_W-1:0];
                    prg_pend_next  = item.data[6];
                    chr_pend_next  = item.data[7];
                end
                REG_BANK_DATA:
                begin
                    bank_regs_next[reg_index_reg] = item.data;
                    pa = bank_regs_next[0] & CHR_PAIR_MASK;
                    pb = bank_regs_next[1] & CHR_PAIR_MASK;
                    if (chr_pend_reg)
                    begin
                        map_next.chr_slot_map[4] = pa;
                        map_next.chr_slot_map[5] = pa + 8'd1;
                        map_next.chr_slot_map[6] = pb;
                        map_next.chr_slot_map[7] = pb + 8'd1;
                        for (int i = 0; i < 4; i++)
                            map_next.chr_slot_map[i] = bank_regs_next[2 + i];
                    end
                    else
                    begin
                        map_next.chr_slot_map[0] = pa;
                        map_next.chr_slot_map[1] = pa + 8'd1;
                        map_next.chr_slot_map[2] = pb;
                        map_next.chr_slot_map[3] = pb + 8'd1;
                        for (int i = 0; i < 4; i++)
                            map_next.chr_slot_map[4 + i] = bank_regs_next[2 + i];
                    end
                    map_next.prg_first  = bank_regs_next[6][PRG_W-1:0];
                    map_next.prg_second = bank_regs_next[7][PRG_W-1:0];
                    map_next.prg_mode   = prg_pend_reg;
                end
                REG_MIRROR:      mirror_next     = item.data[0];
                REG_IRQ_LATCH:   irq_reload_next = item.data - 8'd1;
                REG_IRQ_RELOAD:  irq_count_next  = '0;
                REG_IRQ_DISABLE: irq_on_next     = 1'b0;
                REG_IRQ_ENABLE:  irq_on_next     = 1'b1;
                default:         ;
            endcase
        end
        else if (is_tick)
        begin
            if (irq_count_reg == '0)
                irq_count_next = irq_reload_reg;
            else
            begin
                irq_count_next = irq_count_reg - 8'd1;
                irq_fire       = (irq_count_reg == 8'd1) && irq_on_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bank_regs_reg  <= '0;
            reg_index_reg  <= '0;
            prg_pend_reg   <= 1'b0;
            chr_pend_reg   <= 1'b0;
            map_reg        <= '0;
            irq_reload_reg <= '0;
            irq_count_reg  <= '0;
            irq_on_reg     <= 1'b0;
            mirror_reg     <= 1'b0;
        end
        else if (step)
        begin
            bank_regs_reg  <= bank_regs_next;
            reg_index_reg  <= reg_index_next;
            prg_pend_reg   <= prg_pend_next;
            chr_pend_reg   <= chr_pend_next;
            map_reg        <= map_next;
            irq_reload_reg <= irq_reload_next;
            irq_count_reg  <= irq_count_next;
            irq_on_reg     <= irq_on_next;
            mirror_reg     <= mirror_next;
        end
    end

    assign map_state = map_reg;

endmodule

@@ hdl/bsm_xlate.sv @@
// ----------------------------------------------------------------------------
// bsm_xlate
// address translation of cpu and ppu accesses through the current slot maps
// ----------------------------------------------------------------------------
module bsm_xlate (
    input  bsm_pkg::item_t      item,
    input  bsm_pkg::map_state_t map_state,
    input  logic [5:0]          prg_banks_16k,
    output logic                claimed,
    output bsm_pkg::target_t    target,
    output logic [18:0]         phys_addr
);
    import bsm_pkg::*;

    logic [PRG_W-1:0] fixed_lo;
    logic [PRG_W-1:0] fixed_hi;
    logic [PRG_W-1:0] prg_bank;
    logic [DATA_W-1:0] chr_bank;

    // 2N-2 and 2N-1, modulo 64
    assign fixed_lo = {prg_banks_16k[PRG_W-2:0], 1'b0} + FIXED_OFS_LO;
    assign fixed_hi = {prg_banks_16k[PRG_W-2:0], 1'b0} + FIXED_OFS_HI;

    always_comb
    begin
        case (item.addr[14:13])
            2'd0:    prg_bank = map_state.prg_mode ? fixed_lo : map_state.prg_first;
            2'd1:    prg_bank = map_state.prg_second;
            2'd2:    prg_bank = map_state.prg_mode ? map_state.prg_first : fixed_lo;
            default: prg_bank = fixed_hi;
        endcase
    end

    assign chr_bank = map_state.chr_slot_map[item.addr[12:10]];

    always_comb
    begin
        claimed   = 1'b0;
        target    = TGT_NONE;
        phys_addr = '0;
        case (item.action)
            ACT_CPU_READ:
            begin
                if (item.addr >= PRG_ROM_BASE)
                begin
                    claimed   = 1'b1;
                    target    = TGT_PRG_ROM;
                    phys_addr = {prg_bank, item.addr[12:0]};
                end
                else if (item.addr >= PRG_RAM_BASE)
                begin
                    claimed   = 1'b1;
                    target    = TGT_PRG_RAM;
                    phys_addr = {6'd0, item.addr[12:0]};
                end
            end
            ACT_CPU_WRITE:
            begin
                if (item.addr < PRG_ROM_BASE && item.addr >= PRG_RAM_BASE)
                begin
                    claimed   = 1'b1;
                    target    = TGT_PRG_RAM;
                    phys_addr = {6'd0, item.addr[12:0]};
                end
            end
            ACT_PPU_READ:
            begin
                if (item.addr <= CHR_TOP)
                begin
                    claimed   = 1'b1;
                    target    = TGT_CHR_ROM;
                    phys_addr = {1'b0, chr_bank, item.addr[9:0]};
                end
            end
            default: ;
        endcase
    end

endmodule

@@ hdl/bank_switch_mapper_scanline_irq.sv @@
// ----------------------------------------------------------------------------
// bank_switch_mapper_scanline_irq
// bank switching cartridge mapper with scanline irq counter
// ----------------------------------------------------------------------------
// One bus access or scanline tick per beat, one result beat per input beat,
// in order. The block takes a new beat every cycle while the result side
// keeps up; a beat is held in the input register, then translated, and it
// updates the mapper registers on its way into the result register.
// Throughput is set by the single result register: when out_ready is low
// the input register fills and in_ready drops. The bank count on the
// configuration port is taken every cycle (cfg_ready is always high) and
// is read live by translation.
module bank_switch_mapper_scanline_irq (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [2:0]  action,
    input  logic [15:0] addr,
    input  logic [7:0]  data,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        claimed,
    output logic [1:0]  target,
    output logic [18:0] phys_addr,
    output logic        irq_pulse,
    output logic        mirror_horizontal,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [5:0]  cfg_data
);
    import bsm_pkg::*;

    logic       in_valid_reg;
    item_t      item_reg;
    logic       out_valid_reg;
    logic [5:0] prg_banks_reg;
    logic       advance;

    map_state_t map_state;
    logic       irq_fire;
    logic       mirror_next;
    logic       x_claimed;
    target_t    x_target;
    logic [18:0] x_phys;

    logic        claimed_reg;
    logic [1:0]  target_reg;
    logic [18:0] phys_reg;
    logic        pulse_reg;
    logic        mirror_reg;

    assign advance   = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready  = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            prg_banks_reg <= 6'd2;
        else if (cfg_valid)
            prg_banks_reg <= cfg_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (in_ready)
            in_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            item_reg.action <= action;
            item_reg.addr   <= addr;
            item_reg.data   <= data;
        end
    end

    bsm_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (advance),
        .item        (item_reg),
        .map_state   (map_state),
        .irq_fire    (irq_fire),
        .mirror_next (mirror_next)
    );

    bsm_xlate u_xlate (
        .item          (item_reg),
        .map_state     (map_state),
        .prg_banks_16k (prg_banks_reg),
        .claimed       (x_claimed),
        .target        (x_target),
        .phys_addr     (x_phys)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            claimed_reg <= x_claimed;
            target_reg  <= x_target;
            phys_reg    <= x_phys;
            pulse_reg   <= irq_fire;
            mirror_reg  <= mirror_next;
        end
    end

    assign out_valid         = out_valid_reg;
    assign claimed           = claimed_reg;
    assign target            = target_reg;
    assign phys_addr         = phys_reg;
    assign irq_pulse         = pulse_reg;
    assign mirror_horizontal = mirror_reg;

`ifndef NO_ASSERTIONS
    a_claim_target: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (claimed == (target != TGT_NONE)))
        else $error("claimed disagrees with target");

    a_unclaimed_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !claimed) |-> (phys_addr == '0))
        else $error("unclaimed beat carries an address");

    a_pulse_unclaimed: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && irq_pulse) |-> (target == TGT_NONE))
        else $error("irq pulse on a bus access");

    a_stall_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready && in_valid_reg) |-> !in_ready)
        else $error("input taken with both stages full");

    a_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready && !advance) |=> out_valid)
        else $error("result beat dropped");
`endif

endmodule

@@ test/mapper_checker.sv @@
// ----------------------------------------------------------------------------
// mapper_checker
// Watches the access, result and bank count channels of the mapper. Every
// accepted access beat goes through a local copy of the mapper registers.
// The translation it should produce is queued, and each accepted result
// beat is compared field by field with the oldest queued translation.
// ----------------------------------------------------------------------------
module mapper_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_ready,
    input  logic [2:0]  action,
    input  logic [15:0] addr,
    input  logic [7:0]  data,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic        claimed,
    input  logic [1:0]  target,
    input  logic [18:0] phys_addr,
    input  logic        irq_pulse,
    input  logic        mirror_horizontal,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [5:0]  cfg_data,
    output int          outstanding,
    output int          failures
);
    import bsm_pkg::*;

    localparam logic [PRG_W-1:0] RESET_BANK_COUNT = 6'd2;

    typedef struct packed {
        logic              claimed;
        target_t           target;
        logic [PHYS_W-1:0] phys;
        logic              irq;
        logic              mirror;
    } mapping_t;

    logic [PRG_W-1:0]      bank_count;
    logic [DATA_W-1:0]     bank_regs [NUM_BANK_REGS];
    logic [BANK_IDX_W-1:0] sel_index;
    logic                  prg_mode_sel;
    logic                  chr_mode_sel;
    logic [PRG_W-1:0]      prg_first;
    logic [PRG_W-1:0]      prg_second;
    logic                  prg_swapped;
    logic [DATA_W-1:0]     chr_slots [NUM_CHR_SLOTS];
    logic [DATA_W-1:0]     irq_reload;
    logic [DATA_W-1:0]     irq_cnt;
    logic                  irq_enabled;
    logic                  mirror_h;
    mapping_t              expected_maps [$];
    int                    results_seen;

    function automatic logic [PRG_W-1:0] fixed_bank(input logic [PRG_W-1:0] ofs);
        logic [PRG_W-1:0] doubled;
        doubled = {bank_count[PRG_W-2:0], 1'b0};
        return doubled + ofs;
    endfunction

    function automatic logic [PRG_W-1:0] prg_bank(input logic [1:0] slot);
        case (slot)
            2'd0:    return prg_swapped ? fixed_bank(FIXED_OFS_LO) : prg_first;
            2'd1:    return prg_second;
            2'd2:    return prg_swapped ? prg_first : fixed_bank(FIXED_OFS_LO);
            default: return fixed_bank(FIXED_OFS_HI);
        endcase
    endfunction

    // slot maps follow the bank registers only on a bank data write
    function automatic void load_banks();
        logic [DATA_W-1:0] pair_a;
        logic [DATA_W-1:0] pair_b;
        int                lo;
        int                hi;
        int                i;
        pair_a = bank_regs[0] & CHR_PAIR_MASK;
        pair_b = bank_regs[1] & CHR_PAIR_MASK;
        lo = chr_mode_sel ? 4 : 0;
        hi = chr_mode_sel ? 0 : 4;
        chr_slots[lo]     = pair_a;
        chr_slots[lo + 1] = pair_a + 8'd1;
        chr_slots[lo + 2] = pair_b;
        chr_slots[lo + 3] = pair_b + 8'd1;
        for (i = 0; i < 4; i++)
            chr_slots[hi + i] = bank_regs[2 + i];
        prg_first   = bank_regs[6][PRG_W-1:0];
        prg_second  = bank_regs[7][PRG_W-1:0];
        prg_swapped = prg_mode_sel;
    endfunction

    function automatic void write_register(input logic [ADDR_W-1:0] a,
                                           input logic [DATA_W-1:0] d);
        case (a & REG_ADDR_MASK)
            REG_BANK_SELECT:
            begin
                sel_index    = d[BANK_IDX_W-1:0];
                prg_mode_sel = d[6];
                chr_mode_sel = d[7];
            end
            REG_BANK_DATA:
            begin
                bank_regs[sel_index] = d;
                load_banks();
            end
            REG_MIRROR:      mirror_h = d[0];
            REG_IRQ_LATCH:   irq_reload = d - 8'd1;
            REG_IRQ_RELOAD:  irq_cnt = '0;
            REG_IRQ_DISABLE: irq_enabled = 1'b0;
            REG_IRQ_ENABLE:  irq_enabled = 1'b1;
            default: ;
        endcase
    endfunction

    function automatic mapping_t translate(input logic [2:0]        act,
                                           input logic [ADDR_W-1:0] a,
                                           input logic [DATA_W-1:0] d);
        mapping_t m;
        m = '0;
        case (act)
            ACT_CPU_READ:
            begin
                if (a >= PRG_ROM_BASE)
                begin
                    m.claimed = 1'b1;
                    m.target  = TGT_PRG_ROM;
                    m.phys    = {prg_bank(a[14:13]), a[12:0]};
                end
                else if (a >= PRG_RAM_BASE)
                begin
                    m.claimed = 1'b1;
                    m.target  = TGT_PRG_RAM;
                    m.phys    = {6'd0, a[12:0]};
                end
            end
            ACT_CPU_WRITE:
            begin
                if (a >= PRG_ROM_BASE)
                    write_register(a, d);
                else if (a >= PRG_RAM_BASE)
                begin
                    m.claimed = 1'b1;
                    m.target  = TGT_PRG_RAM;
                    m.phys    = {6'd0, a[12:0]};
                end
            end
            ACT_PPU_READ:
            begin
                if (a <= CHR_TOP)
                begin
                    m.claimed = 1'b1;
                    m.target  = TGT_CHR_ROM;
                    m.phys    = {1'b0, chr_slots[a[12:10]], a[9:0]};
                end
            end
            ACT_SCANLINE:
            begin
                if (irq_cnt == '0)
                    irq_cnt = irq_reload;
                else
                begin
                    irq_cnt = irq_cnt - 8'd1;
                    if (irq_cnt == '0 && irq_enabled)
                        m.irq = 1'b1;
                end
            end
            default: ;
        endcase
        m.mirror = mirror_h;
        return m;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        mapping_t want;
        mapping_t got;
        int       i;
        if (!rst_n)
        begin
            bank_count   = RESET_BANK_COUNT;
            for (i = 0; i < NUM_BANK_REGS; i++)
                bank_regs[i] = '0;
            for (i = 0; i < NUM_CHR_SLOTS; i++)
                chr_slots[i] = '0;
            sel_index    = '0;
            prg_mode_sel = 1'b0;
            chr_mode_sel = 1'b0;
            prg_first    = '0;
            prg_second   = '0;
            prg_swapped  = 1'b0;
            irq_reload   = '0;
            irq_cnt      = '0;
            irq_enabled  = 1'b0;
            mirror_h     = 1'b0;
            expected_maps.delete();
            results_seen = 0;
            outstanding  = 0;
            failures     = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                bank_count = cfg_data;
            if (out_valid && out_ready)
            begin
                got.claimed = claimed;
                got.target  = target_t'(target);
                got.phys    = phys_addr;
                got.irq     = irq_pulse;
                got.mirror  = mirror_horizontal;
                if (expected_maps.size() == 0)
                begin
                    failures++;
                    if (failures <= 10)
                        $display("result beat %0d arrived with nothing expected", results_seen);
                end
                else
                begin
                    want = expected_maps.pop_front();
                    if (got !== want)
                    begin
                        failures++;
                        if (failures <= 10)
                        begin
                            $display("result beat %0d mismatch", results_seen);
                            $display("  exp claimed %0d target %0d phys %05h irq %0d mirror %0d",
                                     want.claimed, want.target, want.phys, want.irq,
                                     want.mirror);
                            $display("  got claimed %0d target %0d phys %05h irq %0d mirror %0d",
                                     got.claimed, got.target, got.phys, got.irq,
                                     got.mirror);
                        end
                    end
                end
                results_seen++;
            end
            if (in_valid && in_ready)
                expected_maps.push_back(translate(action, addr, data));
            outstanding = expected_maps.size();
        end
    end

endmodule

@@ test/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// Drives bus accesses, scanline ticks and bank count writes into the mapper
// with random gaps on both sides and leaves all checking to mapper_checker.
// A short directed sequence comes first, then six random phases, each with
// its own bank count; the idle pattern changes every second phase.
// ----------------------------------------------------------------------------
module testbench;
    import bsm_pkg::*;

    localparam int         RANDOM_ACCESSES  = 2000;
    localparam int         NUM_PHASES       = 6;
    localparam logic [2:0] ACT_UNUSED_FIRST = 3'd5;
    localparam logic [2:0] ACT_UNUSED_LAST  = 3'd7;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [2:0]  action;
    logic [15:0] addr;
    logic [7:0]  data;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic        claimed;
    logic [1:0]  target;
    logic [18:0] phys_addr;
    logic        irq_pulse;
    logic        mirror_horizontal;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [5:0]  cfg_data;

    int outstanding;
    int failures;
    int send_idle_pct;
    int recv_idle_pct;
    int accesses_sent;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    bank_switch_mapper_scanline_irq u_top (
        .clk               (clk),
        .rst_n             (rst_n),
        .in_valid          (in_valid),
        .in_ready          (in_ready),
        .action            (action),
        .addr              (addr),
        .data              (data),
        .out_valid         (out_valid),
        .out_ready         (out_ready),
        .claimed           (claimed),
        .target            (target),
        .phys_addr         (phys_addr),
        .irq_pulse         (irq_pulse),
        .mirror_horizontal (mirror_horizontal),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_data          (cfg_data)
    );

    mapper_checker u_checker (
        .clk               (clk),
        .rst_n             (rst_n),
        .in_valid          (in_valid),
        .in_ready          (in_ready),
        .action            (action),
        .addr              (addr),
        .data              (data),
        .out_valid         (out_valid),
        .out_ready         (out_ready),
        .claimed           (claimed),
        .target            (target),
        .phys_addr         (phys_addr),
        .irq_pulse         (irq_pulse),
        .mirror_horizontal (mirror_horizontal),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_data          (cfg_data),
        .outstanding       (outstanding),
        .failures          (failures)
    );

    always @(negedge clk)
        out_ready <= ($urandom_range(99) >= recv_idle_pct);

    function automatic logic [15:0] reg_address(input logic [15:0] base);
        return base | (16'($urandom) & ~REG_ADDR_MASK);
    endfunction

    // called at a falling edge, returns at the falling edge after the beat
    task automatic send_access(input logic [2:0] act, input logic [15:0] a,
                               input logic [7:0] d);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        action   <= act;
        addr     <= a;
        data     <= d;
        do
            @(posedge clk);
        while (!in_ready);
        @(negedge clk);
        if (act <= ACT_PPU_READ || act == ACT_SCANLINE)
            accesses_sent++;
    endtask

    task automatic wait_for_results();
        in_valid <= 1'b0;
        do
            @(negedge clk);
        while (outstanding != 0);
    endtask

    task automatic write_bank_count(input logic [5:0] v);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
        @(negedge clk);
    endtask

    task automatic random_access();
        int          pick;
        int          ticks;
        logic [15:0] a;
        pick = $urandom_range(99);
        a    = 16'($urandom);
        if (pick < 22)
        begin
            case ($urandom_range(3))
                0:       a = PRG_RAM_BASE | (a & 16'h1FFF);
                1:       ;
                default: a = PRG_ROM_BASE | a;
            endcase
            send_access(ACT_CPU_READ, a, 8'($urandom));
        end
        else if (pick < 32)
        begin
            send_access(ACT_CPU_WRITE, reg_address(REG_BANK_SELECT), 8'($urandom));
            send_access(ACT_CPU_WRITE, reg_address(REG_BANK_DATA), 8'($urandom));
        end
        else if (pick < 40)
        begin
            case ($urandom_range(9))
                0, 1: send_access(ACT_CPU_WRITE, reg_address(REG_MIRROR), 8'($urandom));
                2, 3: send_access(ACT_CPU_WRITE, reg_address(REG_IRQ_LATCH),
                                  8'($urandom_range(1) ? $urandom_range(6) : $urandom));
                4:    send_access(ACT_CPU_WRITE, reg_address(REG_IRQ_RELOAD), 8'($urandom));
                5:    send_access(ACT_CPU_WRITE, reg_address(REG_IRQ_DISABLE), 8'($urandom));
                default:
                      send_access(ACT_CPU_WRITE, reg_address(REG_IRQ_ENABLE), 8'($urandom));
            endcase
        end
        else if (pick < 45)
            send_access(ACT_CPU_WRITE, $urandom_range(1) ? (a & 16'h7FFF) : a, 8'($urandom));
        else if (pick < 70)
            send_access(ACT_PPU_READ, ($urandom_range(99) < 85) ? (a & CHR_TOP) : a,
                        8'($urandom));
        else if (pick < 73)
            send_access(ACT_PPU_WRITE, a, 8'($urandom));
        else if (pick < 97)
        begin
            ticks = $urandom_range(1, 8);
            repeat (ticks)
                send_access(ACT_SCANLINE, 16'($urandom), 8'($urandom));
        end
        else
            send_access(3'($urandom_range(ACT_UNUSED_FIRST, ACT_UNUSED_LAST)), a,
                        8'($urandom));
    endtask

    initial
    begin
        int         phase;
        int         phase_end;
        logic [5:0] count_v;
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        action        = ACT_CPU_READ;
        addr          = '0;
        data          = '0;
        cfg_valid     = 1'b0;
        cfg_data      = '0;
        accesses_sent = 0;
        send_idle_pct = 8;
        recv_idle_pct = 83;
        repeat (5)
            @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: address edges, fixed banks, mode swap, irq latch wrap and pulse
        send_access(ACT_CPU_READ, 16'h0000, 8'h00);
        send_access(ACT_CPU_READ, 16'h5FFF, 8'hFF);
        send_access(ACT_CPU_READ, PRG_RAM_BASE, 8'h00);
        send_access(ACT_CPU_WRITE, 16'h7FFF, 8'hFF);
        send_access(ACT_CPU_WRITE, 16'h1234, 8'h5A);
        send_access(ACT_CPU_READ, PRG_ROM_BASE, 8'h00);
        send_access(ACT_CPU_READ, 16'hFFFF, 8'h00);
        send_access(ACT_CPU_WRITE, REG_BANK_SELECT, 8'hC6);
        send_access(ACT_CPU_WRITE, REG_BANK_DATA, 8'hFF);
        send_access(ACT_CPU_READ, PRG_ROM_BASE, 8'h00);
        send_access(ACT_CPU_READ, 16'hC000, 8'h00);
        send_access(ACT_PPU_READ, 16'h0000, 8'h00);
        send_access(ACT_PPU_READ, CHR_TOP, 8'h00);
        send_access(ACT_PPU_READ, 16'h2000, 8'h00);
        send_access(ACT_PPU_WRITE, 16'h0000, 8'hAA);
        send_access(ACT_CPU_WRITE, REG_MIRROR, 8'h01);
        send_access(ACT_CPU_WRITE, REG_IRQ_LATCH, 8'h00);
        send_access(ACT_CPU_WRITE, REG_IRQ_LATCH, 8'h02);
        send_access(ACT_CPU_WRITE, REG_IRQ_RELOAD, 8'h00);
        send_access(ACT_CPU_WRITE, REG_IRQ_ENABLE, 8'h00);
        send_access(ACT_SCANLINE, 16'h0000, 8'h00);
        send_access(ACT_SCANLINE, 16'hFFFF, 8'hFF);
        send_access(ACT_CPU_WRITE, REG_IRQ_DISABLE, 8'h00);
        send_access(ACT_UNUSED_LAST, 16'hFFFF, 8'hFF);
        send_access(ACT_UNUSED_FIRST, 16'h0000, 8'h00);

        for (phase = 0; phase < NUM_PHASES; phase++)
        begin
            wait_for_results();
            repeat (3)
                @(negedge clk);
            case (phase / 2)
                0:
                begin
                    send_idle_pct = 8;
                    recv_idle_pct = 83;
                end
                1:
                begin
                    send_idle_pct = 83;
                    recv_idle_pct = 8;
                end
                default:
                begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            case (phase)
                0:       count_v = 6'd32;
                1:       count_v = 6'd1;
                2:       count_v = 6'd0;
                3:       count_v = 6'd63;
                default: count_v = 6'($urandom);
            endcase
            write_bank_count(count_v);
            phase_end = accesses_sent + RANDOM_ACCESSES / NUM_PHASES;
            while (accesses_sent < phase_end)
            begin
                random_access();
                if ($urandom_range(199) == 0)
                    wait_for_results();
            end
        end

        wait_for_results();
        repeat (8)
            @(negedge clk);
        if (failures == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    initial
    begin
        #4000000;
        $display("simulation failed");
        $finish;
    end

endmodule
